// ----- rtl/base64_byte_encoder_unit_macros.svh -----
// Assertion macros used by the encoder checker.
`ifndef BASE64_BYTE_ENCODER_UNIT_MACROS_SVH
`define BASE64_BYTE_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define B64E_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b64e check failed");

// Next-cycle implication, disabled while reset is asserted
`define B64E_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b64e check failed");

`endif

// ----- rtl/b64e_pkg.sv -----
// Types, constants and the alphabet mapping of the Base64 encoder.
`timescale 1ns / 1ps

package b64e_pkg;

    // ASCII code of the padding character
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // Number of groups the front/back queue holds
    localparam int QUEUE_DEPTH = 2;

    // One closed group: 24 data bits, count of '=' pads, end-of-message mark
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  pad;
        logic        last;
    } t_group;

    // Map a sextet to its alphabet character
    function automatic logic [7:0] f_sextet_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return 8'h41 + w;
        end else if (v < 6'd52) begin
            return 8'h47 + w;
        end else if (v < 6'd62) begin
            return w - 8'd4;
        end else if (v == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage

// ----- rtl/b64e_front.sv -----
// Front end: accepts bytes, holds a partial group, closes groups.
`timescale 1ns / 1ps

module b64e_front
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_push_valid,
    input  logic       i_push_ready,
    output t_group     o_push_group
);

    logic [15:0] r_pend;
    logic [1:0]  r_cnt;
    logic [15:0] n_pend;
    logic [1:0]  n_cnt;
    logic        accept;
    logic        close;

    // Take a word only when the queue can hold a closed group
    assign o_in_ready = i_push_ready;
    assign accept     = i_in_valid & o_in_ready;
    assign close      = r_cnt[1] | i_last_byte;

    assign o_push_valid = accept & close;

    // Build the group as the held bytes and the new byte leave it
    always_comb begin
        o_push_group.last = i_last_byte;
        if (r_cnt[1]) begin
            o_push_group.bits = {r_pend, i_data_byte};
            o_push_group.pad  = 2'd0;
        end else if (r_cnt == 2'd1) begin
            o_push_group.bits = {r_pend[7:0], i_data_byte, 8'h00};
            o_push_group.pad  = 2'd1;
        end else begin
            o_push_group.bits = {i_data_byte, 16'h0000};
            o_push_group.pad  = 2'd2;
        end
    end

    // Hold or flush the pending bytes
    always_comb begin
        n_pend = r_pend;
        n_cnt  = r_cnt;
        if (accept) begin
            if (close) begin
                n_pend = 16'h0000;
                n_cnt  = 2'd0;
            end else begin
                n_pend = {r_pend[7:0], i_data_byte};
                n_cnt  = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 16'h0000;
            r_cnt  <= 2'd0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ----- rtl/b64e_queue.sv -----
// Short group queue between the front end and the character sequencer.
`timescale 1ns / 1ps

module b64e_queue
    import b64e_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_group i_push_group,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_group o_pop_group
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_group            r_slot [QUEUE_DEPTH];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != CntW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_group  = r_slot[r_rd_ptr];

    assign push = i_push_valid & o_push_ready;
    assign pop  = o_pop_valid & i_pop_ready;

    // Store a pushed group
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_group;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/b64e_back.sv -----
// Back end: each group gives four characters, one per cycle unless stalled.
`timescale 1ns / 1ps

module b64e_back
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pop_valid,
    output logic       o_pop_ready,
    input  t_group     i_pop_group,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_b64_char,
    output logic       o_last_char
);

    t_group      r_grp;
    logic        r_busy;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [7:0]  r_char;
    logic        r_last;
    logic        advance;
    logic        done;
    logic [5:0]  sextet;
    logic [2:0]  pos_sum;
    logic [7:0]  n_char;

    // Move a character into the output register when it is free or draining
    assign advance     = r_busy & (~r_out_valid | i_out_ready);
    assign done        = advance & (r_idx == 2'd3);
    assign o_pop_ready = ~r_busy | done;

    // Pick the sextet for the current position
    always_comb begin
        case (r_idx)
            2'd0:    sextet = r_grp.bits[23:18];
            2'd1:    sextet = r_grp.bits[17:12];
            2'd2:    sextet = r_grp.bits[11:6];
            default: sextet = r_grp.bits[5:0];
        endcase
    end

    // Positions at or past four minus the pad count are '='
    assign pos_sum = {1'b0, r_idx} + {1'b0, r_grp.pad};
    assign n_char  = pos_sum[2] ? CHAR_PAD : f_sextet_char(sextet);

    // Load groups and step through positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            if (i_pop_valid && o_pop_ready) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop_valid && o_pop_ready) begin
            r_grp <= i_pop_group;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_char <= n_char;
            r_last <= r_grp.last & (r_idx == 2'd3);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_b64_char  = r_char;
    assign o_last_char = r_last;

endmodule

// ----- rtl/base64_byte_encoder_unit.sv -----
// Base64 (standard alphabet) streaming encoder, top level.
//
// Input channel: one message byte per word on i_data_byte, with i_last_byte
// set on the final byte of a message; valid/ready handshake.
// Output channel: one ASCII character per word on o_b64_char, with
// o_last_char set on the final character of the encoded message.
// Every three bytes, or a shorter group closed by the last byte, give four
// characters; a short group is zero-filled and padded with one or two '='.
// The first character of a group leaves through the queue slot, the group
// register of the sequencer and the output register. The sequencer sends
// one character per cycle while the receiver takes them; bytes that only
// fill a group are held in the front end and taken while the queue has room.
// A two-group queue sits between the byte front end and the sequencer, and
// the output register holds a character while the receiver stalls; when the
// queue fills, o_in_ready drops until the sequencer takes a group.
// Reset (synchronous, active low) empties the pending bytes, the queue and
// the output register; the next byte opens a new message.
`timescale 1ns / 1ps

module base64_byte_encoder_unit
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_b64_char,
    output logic       o_last_char
);

    logic   push_valid;
    logic   push_ready;
    t_group push_group;
    logic   pop_valid;
    logic   pop_ready;
    t_group pop_group;

    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_group (push_group)
    );

    b64e_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_group (push_group),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_group  (pop_group)
    );

    b64e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (pop_valid),
        .o_pop_ready  (pop_ready),
        .i_pop_group  (pop_group),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_b64_char   (o_b64_char),
        .o_last_char  (o_last_char)
    );

endmodule

// ----- rtl/b64e_checker.sv -----
// Port-level checker for the Base64 encoder and its bind.
`timescale 1ns / 1ps
`include "base64_byte_encoder_unit_macros.svh"

module b64e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_b64_char,
    input logic       o_last_char
);

    logic [1:0] r_pos;
    logic       out_take;
    logic       legal;

    assign out_take = o_out_valid & i_out_ready;

    // Track the position of each character within its group of four
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
        end else if (out_take) begin
            r_pos <= r_pos + 2'd1;
        end
    end

    assign legal = (o_b64_char >= 8'h41 && o_b64_char <= 8'h5A) ||
                   (o_b64_char >= 8'h61 && o_b64_char <= 8'h7A) ||
                   (o_b64_char >= 8'h30 && o_b64_char <= 8'h39) ||
                   (o_b64_char == 8'h2B) || (o_b64_char == 8'h2F) ||
                   (o_b64_char == 8'h3D);

    // A stalled word holds
    `B64E_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_b64_char) && $stable(o_last_char))
    // Only alphabet or pad characters leave the block
    `B64E_ASSERT_NOW(a_char_legal, o_out_valid, legal)
    // The message end falls on the fourth character of a group
    `B64E_ASSERT_NOW(a_last_pos, out_take && o_last_char, r_pos == 2'd3)
    // Padding sits only in the last two places of a group
    `B64E_ASSERT_NOW(a_pad_pos, out_take && o_b64_char == 8'h3D, r_pos == 2'd2 || r_pos == 2'd3)

endmodule

bind base64_byte_encoder_unit b64e_checker u_b64e_checker (.*);
